// File: rtl/ism_pkg.sv
// ism_pkg: shared types and codes for the interval table block
// transaction payload structs, mode and status codes
// no dependencies
package ism_pkg;

	localparam int MODE_BITS    = 2;
	localparam int IN_POS_BITS  = 32;
	localparam int INDEX_BITS   = 4;
	localparam int OUT_POS_BITS = 31;
	localparam int COUNT_BITS   = 5;
	localparam int STATUS_BITS  = 3;

	localparam logic [MODE_BITS-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_READ   = 2'd2;

	localparam logic [STATUS_BITS-1:0] STATUS_OK     = 3'd0;
	localparam logic [STATUS_BITS-1:0] STATUS_SAME   = 3'd1;
	localparam logic [STATUS_BITS-1:0] STATUS_REJECT = 3'd2;
	localparam logic [STATUS_BITS-1:0] STATUS_FULL   = 3'd3;
	localparam logic [STATUS_BITS-1:0] STATUS_BADIDX = 3'd4;

	typedef struct packed {
		logic [MODE_BITS-1:0]          mode;
		logic signed [IN_POS_BITS-1:0] interval_start;
		logic signed [IN_POS_BITS-1:0] interval_stop;
		logic [INDEX_BITS-1:0]         read_index;
	} in_item_t;

	typedef struct packed {
		logic [OUT_POS_BITS-1:0] entry_start;
		logic [OUT_POS_BITS-1:0] entry_stop;
		logic [COUNT_BITS-1:0]   entry_count;
		logic [STATUS_BITS-1:0]  status;
	} out_item_t;

endpackage

// File: rtl/ism_ram.sv
// ism_ram: generic single-write, single-read synchronous RAM
// read data registered; no dependencies
module ism_ram #(
	parameter int WIDTH = 62,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/interval_set_insert_merge.sv
// interval_set_insert_merge: sorted disjoint interval table with merge on insert
// depends on ism_pkg and ism_ram (one table memory holding start and stop)
// read: states ST_READ and ST_READ_WAIT fetch the entry, ST_FINISH presents the result
// insert/remove: one scan pass and, for a committed edit, one shift pass over the
//   single-read-port table memory; one transaction at a time
// reset clears the entry count and control state; table contents stay undefined, no clearing pass
module interval_set_insert_merge #(
	parameter int TABLE_DEPTH   = 16,
	parameter int POSITION_BITS = 31
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ism_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ism_pkg::out_item_t  out_data
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int IW = (CW > ism_pkg::INDEX_BITS) ? CW : ism_pkg::INDEX_BITS;
	localparam int PB = POSITION_BITS;
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_READ_WAIT,
		ST_SCAN,
		ST_DECIDE,
		ST_SHIFT,
		ST_MERGE,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [ism_pkg::MODE_BITS-1:0]   op_q;
	logic [PB-1:0]                   s_q, e_q;
	logic [IW-1:0]                   idx_q;
	logic [CW-1:0]                   used_q;

	logic [CW-1:0]                   rd_ptr_q;
	logic                            scan_v_s1;
	logic [CW-1:0]                   scan_idx_s1;
	logic [CW-1:0]                   lo_q, after_q, match_q;
	logic                            contain_q, found_q;
	logic [PB-1:0]                   ms_q, me_q;

	logic [CW-1:0]                   sh_src_q, sh_left_q, sh_off_q;
	logic                            sh_up_q;
	logic                            sh_v_s1;
	logic [CW-1:0]                   sh_dst_s1;
	logic                            merge_q;
	logic [CW-1:0]                   merge_at_q;

	logic [ism_pkg::STATUS_BITS-1:0] res_status_q;
	logic [PB-1:0]                   res_start_q, res_stop_q;

	logic                            out_valid_q;
	ism_pkg::out_item_t              out_q;

	// table memory ports
	logic                            rd_en, wr_en;
	logic [AW-1:0]                   rd_addr, wr_addr;
	logic [2*PB-1:0]                 wr_data, rd_data;
	logic [PB-1:0]                   rd_start, rd_stop;

	// input checks
	logic [63:0]                     raw_s64, raw_e64;
	logic                            s_ok, e_ok, geom_ok;
	logic [PB-1:0]                   s_val, e_val;
	logic [IW-1:0]                   in_idx;

	logic [CW-1:0]                   hits;
	logic [63:0]                     res_start64, res_stop64;
	logic [31:0]                     used32;

	assign raw_s64 = {32'd0, in_data.interval_start};
	assign raw_e64 = {32'd0, in_data.interval_stop};
	assign s_ok    = !in_data.interval_start[31] && ((raw_s64 >> PB) == 64'd0);
	assign e_ok    = !in_data.interval_stop[31] && ((raw_e64 >> PB) == 64'd0);
	assign s_val   = raw_s64[PB-1:0];
	assign e_val   = raw_e64[PB-1:0];
	assign geom_ok = s_ok && e_ok && (s_val <= e_val);
	assign in_idx  = IW'(in_data.read_index);

	assign rd_start = rd_data[2*PB-1:PB];
	assign rd_stop  = rd_data[PB-1:0];

	assign hits = used_q - lo_q - after_q;

	assign res_start64 = 64'(res_start_q);
	assign res_stop64  = 64'(res_stop_q);
	assign used32      = 32'(used_q);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	ism_ram #(
		.WIDTH (2 * PB),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		unique case (state_q)
			ST_READ: begin
				rd_en   = 1'b1;
				rd_addr = idx_q[AW-1:0];
			end
			ST_SCAN: begin
				rd_en   = (rd_ptr_q != used_q);
				rd_addr = rd_ptr_q[AW-1:0];
			end
			ST_SHIFT: begin
				rd_en   = (sh_left_q != '0);
				rd_addr = sh_src_q[AW-1:0];
				wr_en   = sh_v_s1;
				wr_addr = sh_dst_s1[AW-1:0];
				wr_data = rd_data;
			end
			ST_MERGE: begin
				wr_en   = 1'b1;
				wr_addr = merge_at_q[AW-1:0];
				wr_data = {ms_q, me_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			scan_v_s1   <= 1'b0;
			sh_v_s1     <= 1'b0;
		end else begin
			scan_v_s1 <= (state_q == ST_SCAN) && (rd_ptr_q != used_q);
			sh_v_s1   <= (state_q == ST_SHIFT) && (sh_left_q != '0);
			if (out_valid_q && out_ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q        <= in_data.mode;
						s_q         <= s_val;
						e_q         <= e_val;
						idx_q       <= in_idx;
						res_start_q <= '0;
						res_stop_q  <= '0;
						case (in_data.mode) inside
							ism_pkg::MODE_INSERT, ism_pkg::MODE_REMOVE: begin
								if (geom_ok) begin
									rd_ptr_q  <= '0;
									lo_q      <= '0;
									after_q   <= '0;
									match_q   <= '0;
									contain_q <= 1'b0;
									found_q   <= 1'b0;
									ms_q      <= s_val;
									me_q      <= e_val;
									state_q   <= ST_SCAN;
								end else begin
									res_status_q <= ism_pkg::STATUS_REJECT;
									state_q      <= ST_FINISH;
								end
							end
							ism_pkg::MODE_READ: begin
								if (in_idx < IW'(used_q)) begin
									state_q <= ST_READ;
								end else begin
									res_status_q <= ism_pkg::STATUS_BADIDX;
									state_q      <= ST_FINISH;
								end
							end
							default: begin
								res_status_q <= ism_pkg::STATUS_REJECT;
								state_q      <= ST_FINISH;
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_READ_WAIT;
				end
				ST_READ_WAIT: begin
					res_start_q  <= rd_start;
					res_stop_q   <= rd_stop;
					res_status_q <= ism_pkg::STATUS_OK;
					state_q      <= ST_FINISH;
				end
				ST_SCAN: begin
					if (rd_ptr_q != used_q) begin
						rd_ptr_q    <= rd_ptr_q + ONE_C;
						scan_idx_s1 <= rd_ptr_q;
					end
					if (scan_v_s1) begin
						if (rd_start <= s_q && e_q <= rd_stop) begin
							contain_q <= 1'b1;
						end
						if (rd_stop < s_q) begin
							lo_q <= lo_q + ONE_C;
						end else if (rd_start > e_q) begin
							after_q <= after_q + ONE_C;
						end else begin
							// overlapping entry widens the merged interval
							if (rd_start < ms_q) begin
								ms_q <= rd_start;
							end
							if (rd_stop > me_q) begin
								me_q <= rd_stop;
							end
						end
						if (rd_start == s_q && rd_stop == e_q) begin
							found_q <= 1'b1;
							match_q <= scan_idx_s1;
						end
					end
					if (rd_ptr_q == used_q && !scan_v_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (op_q == ism_pkg::MODE_INSERT) begin
						if (contain_q) begin
							res_status_q <= ism_pkg::STATUS_SAME;
							state_q      <= ST_FINISH;
						end else if (hits == '0 && used_q == DEPTH_C) begin
							res_status_q <= ism_pkg::STATUS_FULL;
							state_q      <= ST_FINISH;
						end else begin
							res_status_q <= ism_pkg::STATUS_OK;
							used_q       <= used_q - hits + ONE_C;
							merge_q      <= 1'b1;
							merge_at_q   <= lo_q;
							state_q      <= ST_SHIFT;
							if (hits == '0) begin
								// open a gap at the insert point
								sh_up_q   <= 1'b1;
								sh_src_q  <= used_q - ONE_C;
								sh_left_q <= used_q - lo_q;
								sh_off_q  <= ONE_C;
							end else begin
								// close the gap left by absorbed entries
								sh_up_q   <= 1'b0;
								sh_src_q  <= lo_q + hits;
								sh_left_q <= (hits == ONE_C) ? '0 : after_q;
								sh_off_q  <= hits - ONE_C;
							end
						end
					end else begin
						if (found_q) begin
							res_status_q <= ism_pkg::STATUS_OK;
							used_q       <= used_q - ONE_C;
							merge_q      <= 1'b0;
							sh_up_q      <= 1'b0;
							sh_src_q     <= match_q + ONE_C;
							sh_left_q    <= used_q - match_q - ONE_C;
							sh_off_q     <= ONE_C;
							state_q      <= ST_SHIFT;
						end else begin
							res_status_q <= ism_pkg::STATUS_SAME;
							state_q      <= ST_FINISH;
						end
					end
				end
				ST_SHIFT: begin
					if (sh_left_q != '0) begin
						sh_dst_s1 <= sh_up_q ? (sh_src_q + sh_off_q) : (sh_src_q - sh_off_q);
						sh_src_q  <= sh_up_q ? (sh_src_q - ONE_C) : (sh_src_q + ONE_C);
						sh_left_q <= sh_left_q - ONE_C;
					end
					if (sh_left_q == '0 && !sh_v_s1) begin
						state_q <= merge_q ? ST_MERGE : ST_FINISH;
					end
				end
				ST_MERGE: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q       <= 1'b1;
						out_q.entry_start <= res_start64[ism_pkg::OUT_POS_BITS-1:0];
						out_q.entry_stop  <= res_stop64[ism_pkg::OUT_POS_BITS-1:0];
						out_q.entry_count <= used32[ism_pkg::COUNT_BITS-1:0];
						out_q.status      <= res_status_q;
						state_q           <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// shifting never reads and writes the same entry in one cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_addr))
		else $error("table read and write collide");

	// the entry count only moves when an edit is committed
	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(used_q) |-> ($past(state_q) == ST_DECIDE))
		else $error("entry count changed outside decision");

	// a finished result is presented and the block goes idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && (!out_valid_q || out_ready)) |=>
		(out_valid_q && state_q == ST_IDLE))
		else $error("result not presented after finish");

	// an accepted transaction always starts work
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q != ST_IDLE))
		else $error("accepted transaction dropped");
`endif

endmodule

// File: dv/tb_interval_set_insert_merge.sv
// tb_interval_set_insert_merge: self-checking testbench for the interval table block
// directed and random insert/remove/read transactions, scoreboard with its own table model
// depends on ism_pkg and the interval_set_insert_merge rtl

class interval_table_tracker;
	localparam int DEPTH = 16;
	localparam int SHOW_LIMIT = 10;

	logic [ism_pkg::OUT_POS_BITS-1:0] lo [DEPTH];
	logic [ism_pkg::OUT_POS_BITS-1:0] hi [DEPTH];
	int unsigned                      used;
	ism_pkg::out_item_t               awaited[$];
	int unsigned                      errors;
	int unsigned                      shown;

	function new();
		used = 0;
		errors = 0;
		shown = 0;
		foreach (lo[i]) begin
			lo[i] = '0;
			hi[i] = '0;
		end
	endfunction

	function bit well_formed(ism_pkg::in_item_t it,
		output logic [ism_pkg::OUT_POS_BITS-1:0] s,
		output logic [ism_pkg::OUT_POS_BITS-1:0] e);
		s = it.interval_start[ism_pkg::OUT_POS_BITS-1:0];
		e = it.interval_stop[ism_pkg::OUT_POS_BITS-1:0];
		return !it.interval_start[ism_pkg::IN_POS_BITS-1] &&
			!it.interval_stop[ism_pkg::IN_POS_BITS-1] && s <= e;
	endfunction

	function logic [ism_pkg::STATUS_BITS-1:0] merge_insert(
		logic [ism_pkg::OUT_POS_BITS-1:0] s, logic [ism_pkg::OUT_POS_BITS-1:0] e);
		logic [ism_pkg::OUT_POS_BITS-1:0] ns [DEPTH];
		logic [ism_pkg::OUT_POS_BITS-1:0] ne [DEPTH];
		logic [ism_pkg::OUT_POS_BITS-1:0] ms;
		logic [ism_pkg::OUT_POS_BITS-1:0] me;
		int unsigned                      k;
		int unsigned                      hits;
		bit                               placed;
		ms = s;
		me = e;
		k = 0;
		hits = 0;
		placed = 1'b0;
		for (int i = 0; i < used; i++)
			if (lo[i] <= s && e <= hi[i])
				return ism_pkg::STATUS_SAME;
		for (int i = 0; i < used; i++) begin
			if (lo[i] <= e && s <= hi[i]) begin
				hits++;
				if (lo[i] < ms)
					ms = lo[i];
				if (hi[i] > me)
					me = hi[i];
			end
		end
		if (hits == 0 && used >= DEPTH)
			return ism_pkg::STATUS_FULL;
		for (int i = 0; i < used; i++) begin
			if (lo[i] <= e && s <= hi[i])
				continue;
			if (!placed && lo[i] > me) begin
				ns[k] = ms;
				ne[k] = me;
				k++;
				placed = 1'b1;
			end
			if (k < DEPTH) begin
				ns[k] = lo[i];
				ne[k] = hi[i];
				k++;
			end
		end
		if (!placed && k < DEPTH) begin
			ns[k] = ms;
			ne[k] = me;
			k++;
		end
		for (int i = 0; i < k; i++) begin
			lo[i] = ns[i];
			hi[i] = ne[i];
		end
		used = k;
		return ism_pkg::STATUS_OK;
	endfunction

	function logic [ism_pkg::STATUS_BITS-1:0] exact_remove(
		logic [ism_pkg::OUT_POS_BITS-1:0] s, logic [ism_pkg::OUT_POS_BITS-1:0] e);
		for (int i = 0; i < used; i++) begin
			if (lo[i] == s && hi[i] == e) begin
				for (int j = i; j + 1 < used; j++) begin
					lo[j] = lo[j+1];
					hi[j] = hi[j+1];
				end
				used--;
				return ism_pkg::STATUS_OK;
			end
		end
		return ism_pkg::STATUS_SAME;
	endfunction

	function void note_input(ism_pkg::in_item_t it);
		ism_pkg::out_item_t               exp;
		logic [ism_pkg::OUT_POS_BITS-1:0] s;
		logic [ism_pkg::OUT_POS_BITS-1:0] e;
		exp = '0;
		if (it.mode == ism_pkg::MODE_INSERT || it.mode == ism_pkg::MODE_REMOVE) begin
			if (!well_formed(it, s, e))
				exp.status = ism_pkg::STATUS_REJECT;
			else if (it.mode == ism_pkg::MODE_INSERT)
				exp.status = merge_insert(s, e);
			else
				exp.status = exact_remove(s, e);
		end else if (it.mode == ism_pkg::MODE_READ) begin
			if (it.read_index < used) begin
				exp.entry_start = lo[it.read_index];
				exp.entry_stop = hi[it.read_index];
				exp.status = ism_pkg::STATUS_OK;
			end else begin
				exp.status = ism_pkg::STATUS_BADIDX;
			end
		end else begin
			exp.status = ism_pkg::STATUS_REJECT;
		end
		exp.entry_count = used[ism_pkg::COUNT_BITS-1:0];
		awaited.insert(awaited.size(), exp);
	endfunction

	function void check_result(ism_pkg::out_item_t got);
		ism_pkg::out_item_t exp;
		if (awaited.size() == 0) begin
			errors++;
			if (shown < SHOW_LIMIT) begin
				shown++;
				$display("unexpected result: start %0d stop %0d count %0d status %0d",
					got.entry_start, got.entry_stop, got.entry_count, got.status);
			end
			return;
		end
		exp = awaited.pop_front();
		if (got.entry_start !== exp.entry_start || got.entry_stop !== exp.entry_stop ||
			got.entry_count !== exp.entry_count || got.status !== exp.status) begin
			errors++;
			if (shown < SHOW_LIMIT) begin
				shown++;
				$display("result mismatch: expected start %0d stop %0d count %0d status %0d",
					exp.entry_start, exp.entry_stop, exp.entry_count, exp.status);
				$display("                 actual   start %0d stop %0d count %0d status %0d",
					got.entry_start, got.entry_stop, got.entry_count, got.status);
			end
		end
	endfunction
endclass

module tb_interval_set_insert_merge;

	localparam logic [ism_pkg::MODE_BITS-1:0] MODE_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 1200;
	localparam int QUIET_FROM   = 1050;
	localparam int STALL_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 60;

	localparam int ROUND_FILL  = 0;
	localparam int ROUND_CHURN = 1;
	localparam int ROUND_NOISE = 2;
	localparam int ROUND_SWEEP = 3;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	ism_pkg::in_item_t  in_data = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	ism_pkg::out_item_t out_data;

	int unsigned send_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	bit          quiet = 1'b0;
	int unsigned random_sent = 0;

	interval_table_tracker tracker = new();

	interval_set_insert_merge i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if (in_valid && in_ready)
			tracker.note_input(in_data);
		if (out_valid && out_ready)
			tracker.check_result(out_data);
	end

	// result side back-pressure in bursts
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 99) < sink_stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 20)) @(posedge clk);
		end
	end

	initial begin : watchdog
		int unsigned stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("Mismatches found");
		$finish;
	end

	function automatic ism_pkg::in_item_t make_item(logic [ism_pkg::MODE_BITS-1:0] m,
		logic [31:0] s, logic [31:0] e, logic [ism_pkg::INDEX_BITS-1:0] idx);
		ism_pkg::in_item_t it;
		it.mode = m;
		it.interval_start = s;
		it.interval_stop = e;
		it.read_index = idx;
		return it;
	endfunction

	task automatic drive_item(ism_pkg::in_item_t it);
		if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	task automatic drive_edit(logic [ism_pkg::MODE_BITS-1:0] m, logic [31:0] s,
		logic [31:0] e);
		drive_item(make_item(m, s, e, 4'($urandom_range(0, 15))));
	endtask

	task automatic drive_read(logic [ism_pkg::INDEX_BITS-1:0] idx);
		drive_item(make_item(ism_pkg::MODE_READ, $urandom, $urandom, idx));
	endtask

	function automatic logic [ism_pkg::INDEX_BITS-1:0] pick_index();
		if (tracker.used != 0 && $urandom_range(0, 9) < 7)
			return 4'($urandom_range(0, tracker.used - 1));
		return 4'($urandom_range(0, 15));
	endfunction

	// malformed interval: negative field, swapped ends or spare mode
	task automatic drive_broken(logic [31:0] base);
		logic [31:0] s;
		logic [31:0] e;
		s = base + $urandom_range(0, 300);
		e = s + $urandom_range(1, 30);
		case ($urandom_range(0, 3))
			0: drive_edit(2'($urandom_range(0, 1)), s | 32'h8000_0000, e);
			1: drive_edit(2'($urandom_range(0, 1)), s, e | 32'h8000_0000);
			2: drive_edit(2'($urandom_range(0, 1)), e, s);
			default: drive_edit(MODE_SPARE, s, e);
		endcase
	endtask

	task automatic run_round(int kind, int n);
		logic [31:0] base;
		logic [31:0] s;
		logic [31:0] e;
		int unsigned pick;
		int unsigned k;
		base = ($urandom_range(0, 3) == 0) ? ($urandom & 32'h7fff_0000) : 32'h0;
		for (int i = 0; i < n; i++) begin
			case (kind)
				ROUND_FILL: begin
					s = base + $urandom_range(0, 60000);
					e = s + $urandom_range(0, 40);
					if ($urandom_range(0, 4) == 0)
						drive_read(pick_index());
					else
						drive_edit(ism_pkg::MODE_INSERT, s, e);
				end
				ROUND_CHURN: begin
					s = base + $urandom_range(0, 300);
					e = s + $urandom_range(0, 30);
					pick = $urandom_range(0, 9);
					if (pick < 4) begin
						drive_edit(ism_pkg::MODE_INSERT, s, e);
					end else if (pick < 7) begin
						if (tracker.used != 0 && $urandom_range(0, 9) < 7) begin
							k = $urandom_range(0, tracker.used - 1);
							if ($urandom_range(0, 3) == 0)
								drive_edit(ism_pkg::MODE_REMOVE, {1'b0, tracker.lo[k]},
									{1'b0, tracker.hi[k]} + 32'd1);
							else
								drive_edit(ism_pkg::MODE_REMOVE, {1'b0, tracker.lo[k]},
									{1'b0, tracker.hi[k]});
						end else begin
							drive_edit(ism_pkg::MODE_REMOVE, s, e);
						end
					end else if (pick < 9) begin
						drive_read(pick_index());
					end else begin
						drive_broken(base);
					end
				end
				ROUND_NOISE:
					drive_item(make_item(2'($urandom_range(0, 3)), $urandom, $urandom,
						4'($urandom_range(0, 15))));
				default:
					drive_read(4'(i % 16));
			endcase
			random_sent++;
			if (random_sent >= QUIET_FROM)
				quiet = 1'b1;
		end
	endtask

	task automatic run_directed();
		drive_read(4'd0);
		drive_edit(ism_pkg::MODE_INSERT, 32'd0, 32'd0);
		drive_read(4'd0);
		drive_edit(ism_pkg::MODE_INSERT, 32'd0, 32'd0);
		drive_edit(ism_pkg::MODE_INSERT, 32'hffff_ffff, 32'd5);
		drive_edit(ism_pkg::MODE_INSERT, 32'd3, 32'hffff_fff9);
		drive_edit(ism_pkg::MODE_INSERT, 32'd9, 32'd4);
		drive_edit(ism_pkg::MODE_INSERT, 32'h8000_0000, 32'h7fff_ffff);
		drive_edit(MODE_SPARE, 32'd60, 32'd70);
		drive_edit(ism_pkg::MODE_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
		drive_edit(ism_pkg::MODE_INSERT, 32'd10, 32'd20);
		drive_edit(ism_pkg::MODE_INSERT, 32'd20, 32'd30);
		drive_edit(ism_pkg::MODE_INSERT, 32'd40, 32'd50);
		drive_edit(ism_pkg::MODE_INSERT, 32'd5, 32'd45);
		drive_edit(ism_pkg::MODE_INSERT, 32'd12, 32'd13);
		drive_edit(ism_pkg::MODE_REMOVE, 32'd5, 32'd50);
		drive_edit(ism_pkg::MODE_REMOVE, 32'd5, 32'd50);
		drive_edit(ism_pkg::MODE_REMOVE, 32'hffff_fffd, 32'd4);
		drive_edit(ism_pkg::MODE_REMOVE, 32'd7, 32'd6);
		drive_read(4'd15);
		drive_read(4'd1);
		drive_edit(ism_pkg::MODE_INSERT, 32'd1, 32'd1);
		drive_edit(ism_pkg::MODE_INSERT, 32'd0, 32'h7fff_ffff);
		drive_edit(ism_pkg::MODE_REMOVE, 32'd0, 32'h7fff_ffff);
		drive_read(4'd0);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		while (random_sent < RANDOM_ITEMS) begin
			if (!quiet) begin
				send_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
				sink_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
			end
			case ($urandom_range(0, 9))
				0, 1, 2:    run_round(ROUND_FILL, $urandom_range(20, 40));
				3, 4, 5, 6: run_round(ROUND_CHURN, $urandom_range(20, 50));
				7, 8:       run_round(ROUND_NOISE, $urandom_range(5, 15));
				default:    run_round(ROUND_SWEEP, 16);
			endcase
		end
		in_valid <= 1'b0;
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.awaited.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: files.f
rtl/ism_pkg.sv
rtl/ism_ram.sv
rtl/interval_set_insert_merge.sv
dv/tb_interval_set_insert_merge.sv
